/* hw/rtl/trap_pkg.sv */
// Shared types, constants and latencies for the triangle rotation block.
package trap_pkg;

    // Build-time configuration.
    localparam int CORDIC_STAGES = 16;
    localparam int FRAC_BITS     = 16;

    // The arctangent table has a fixed length, and it caps the number of stages.
    localparam int ATAN_LEN = 30;
    localparam int NSTG     = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

    // Datapath widths.
    localparam int COORD_W = 32;
    localparam int XY_W    = 34;
    localparam int Z_W     = 34;

    // Arctangent table for 2^-i, Q2.30, truncated.
    localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
        32'd33543515,  32'd16775850,  32'd8388437,   32'd4194282,   32'd2097149,
        32'd1048575,   32'd524287,    32'd262143,    32'd131071,    32'd65535,
        32'd32767,     32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127,       32'd63,
        32'd31,        32'd15,        32'd8,         32'd4,         32'd2
    };

    // CORDIC start value (gain compensation) and pi, both Q2.30.
    localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [31:0]            PI_Q30   = 32'd3373259426;

    // Angle constants in the input's degree format.
    localparam longint FULL_ANG    = longint'(360) << FRAC_BITS;
    localparam longint HALF_ANG    = longint'(180) << FRAC_BITS;
    localparam longint QUARTER_ANG = longint'(90) << FRAC_BITS;

    // A whole number of turns added so that the wrap works on a non-negative value.
    localparam longint ANG_OFFSET =
        (((longint'(1) << 31) + FULL_ANG - 1) / FULL_ANG) * FULL_ANG;
    localparam int     MOD_W     = 34;
    localparam longint MAX_RED   = (longint'(1) << 31) - 1 + ANG_OFFSET;
    localparam int     MOD_STEPS = $clog2(MAX_RED / FULL_ANG + 1);

    // Widths of the folded angle and the degree-to-radian conversion.
    localparam int     RES_W      = $clog2(FULL_ANG);
    localparam int     MAG_W      = $clog2(QUARTER_ANG + 1);
    localparam int     PROD_W     = MAG_W + 32;
    // 180 << FRAC_BITS is 45 << (FRAC_BITS + 2): a shift, then a divide by 45.
    localparam int     DIV_SHIFT  = FRAC_BITS + 2;
    localparam longint RND_ANG    = HALF_ANG / 2;
    localparam int     NUM_W      = PROD_W + 1 - DIV_SHIFT;
    localparam int     DIV_BITS   = 4;
    localparam int     DIV_STAGES = (NUM_W + DIV_BITS - 1) / DIV_BITS;
    localparam int     DIV_W      = DIV_STAGES * DIV_BITS;
    localparam int     DIV_DEN    = 45;
    localparam int     REM_W      = 6;

    // Pipeline latencies in clock cycles.
    localparam int RED_LAT    = 1 + MOD_STEPS + 1 + 1 + 1 + DIV_STAGES + 1;
    localparam int CORDIC_LAT = NSTG + 1;
    localparam int LANE_LAT   = 4;
    localparam int PAY_LAT    = RED_LAT + CORDIC_LAT;
    localparam int TOTAL_LAT  = PAY_LAT + LANE_LAT;

    // Request: angle, pivot and three vertices.
    typedef struct packed {
        logic signed [COORD_W-1:0] angle_deg;
        logic signed [COORD_W-1:0] pivot_x;
        logic signed [COORD_W-1:0] pivot_y;
        logic signed [COORD_W-1:0] vert_a_x;
        logic signed [COORD_W-1:0] vert_a_y;
        logic signed [COORD_W-1:0] vert_b_x;
        logic signed [COORD_W-1:0] vert_b_y;
        logic signed [COORD_W-1:0] vert_c_x;
        logic signed [COORD_W-1:0] vert_c_y;
    } request_t;

    // Result: the three rotated vertices.
    typedef struct packed {
        logic signed [COORD_W-1:0] rot_a_x;
        logic signed [COORD_W-1:0] rot_a_y;
        logic signed [COORD_W-1:0] rot_b_x;
        logic signed [COORD_W-1:0] rot_b_y;
        logic signed [COORD_W-1:0] rot_c_x;
        logic signed [COORD_W-1:0] rot_c_y;
    } result_t;

    // Folded angle in radians, plus the flag that negates cosine and sine.
    typedef struct packed {
        logic signed [Z_W-1:0] z;
        logic                  neg;
    } angle_t;

    // Cosine and sine, Q2.30.
    typedef struct packed {
        logic signed [31:0] cos_v;
        logic signed [31:0] sin_v;
    } trig_t;

    // One point.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

endpackage

/* hw/rtl/trap_reduce.sv */
// Angle reduction pipeline: wrap to one turn, fold to +/-90 degrees, convert to radians.
module trap_reduce (
    input  logic                                 clk,
    input  logic signed [trap_pkg::COORD_W-1:0] angle_deg,
    output trap_pkg::angle_t                     angle
);

    localparam int MOD_W  = trap_pkg::MOD_W;
    localparam int RES_W  = trap_pkg::RES_W;
    localparam int MAG_W  = trap_pkg::MAG_W;
    localparam int PROD_W = trap_pkg::PROD_W;
    localparam int DIV_W  = trap_pkg::DIV_W;
    localparam int DIV_B  = trap_pkg::DIV_BITS;
    localparam int NDIV   = trap_pkg::DIV_STAGES;
    localparam int REM_W  = trap_pkg::REM_W;
    localparam int NMOD   = trap_pkg::MOD_STEPS;
    localparam int Z_W    = trap_pkg::Z_W;

    logic [MOD_W-1:0]  off_reg;
    logic [MOD_W-1:0]  mod_reg [NMOD];
    logic [MAG_W-1:0]  mag_reg;
    logic              msign_f_reg, neg_f_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              msign_p_reg, neg_p_reg;
    logic [DIV_W-1:0]  num_reg;
    logic              msign_n_reg, neg_n_reg;
    logic [REM_W-1:0]  rem_reg  [NDIV];
    logic [DIV_W-1:0]  dnum_reg [NDIV];
    logic [DIV_W-1:0]  quo_reg  [NDIV];
    logic              dsgn_reg [NDIV];
    logic              dneg_reg [NDIV];
    trap_pkg::angle_t  angle_reg;

    // Shift the angle up by whole turns so that it is non-negative.
    always_ff @(posedge clk)
    begin
        off_reg <= MOD_W'(angle_deg) + MOD_W'(trap_pkg::ANG_OFFSET);
    end

    // Modulo one turn by compare and subtract, one multiple of a turn a stage.
    for (genvar j = 0; j < NMOD; j++) begin : g_mod
        logic [MOD_W-1:0] m_in;
        if (j == 0) begin : g_first
            assign m_in = off_reg;
        end else begin : g_next
            assign m_in = mod_reg[j-1];
        end
        always_ff @(posedge clk)
        begin
            if (m_in >= MOD_W'(trap_pkg::FULL_ANG << (NMOD - 1 - j)))
            begin
                mod_reg[j] <= m_in - MOD_W'(trap_pkg::FULL_ANG << (NMOD - 1 - j));
            end
            else
            begin
                mod_reg[j] <= m_in;
            end
        end
    end

    // Fold into [-90, 90] degrees and take the magnitude.
    always_ff @(posedge clk)
    begin
        logic [RES_W-1:0]        m;
        logic signed [RES_W:0]   ms;
        logic signed [RES_W:0]   mf;
        logic                    ng;
        m  = mod_reg[NMOD-1][RES_W-1:0];
        ms = signed'({1'b0, m});
        ng = 1'b0;
        if (({1'b0, m} > (RES_W+1)'(trap_pkg::QUARTER_ANG))
            && ({1'b0, m} <= (RES_W+1)'(3 * trap_pkg::QUARTER_ANG)))
        begin
            mf = ms - signed'((RES_W+1)'(trap_pkg::HALF_ANG));
            ng = 1'b1;
        end
        else if ({1'b0, m} > (RES_W+1)'(3 * trap_pkg::QUARTER_ANG))
        begin
            mf = ms - signed'((RES_W+1)'(trap_pkg::FULL_ANG));
        end
        else
        begin
            mf = ms;
        end
        mag_reg     <= (mf < 0) ? MAG_W'(-mf) : MAG_W'(mf);
        msign_f_reg <= mf[RES_W];
        neg_f_reg   <= ng;
    end

    // Scale the magnitude by pi.
    always_ff @(posedge clk)
    begin
        prod_reg    <= PROD_W'(mag_reg) * PROD_W'(trap_pkg::PI_Q30);
        msign_p_reg <= msign_f_reg;
        neg_p_reg   <= neg_f_reg;
    end

    // Add half the divisor for rounding and take out its power-of-two factor.
    always_ff @(posedge clk)
    begin
        logic [PROD_W:0] sum;
        sum = {1'b0, prod_reg} + (PROD_W+1)'(trap_pkg::RND_ANG);
        num_reg     <= DIV_W'(sum >> trap_pkg::DIV_SHIFT);
        msign_n_reg <= msign_p_reg;
        neg_n_reg   <= neg_p_reg;
    end

    // Long division by 45, a few quotient bits a stage.
    for (genvar s = 0; s < NDIV; s++) begin : g_div
        logic [REM_W-1:0] r_in;
        logic [DIV_W-1:0] n_in, q_in;
        logic             s_in, g_in;
        logic [REM_W-1:0] r_out;
        logic [DIV_B-1:0] qb;
        if (s == 0) begin : g_first
            assign r_in = '0;
            assign n_in = num_reg;
            assign q_in = '0;
            assign s_in = msign_n_reg;
            assign g_in = neg_n_reg;
        end else begin : g_next
            assign r_in = rem_reg[s-1];
            assign n_in = dnum_reg[s-1];
            assign q_in = quo_reg[s-1];
            assign s_in = dsgn_reg[s-1];
            assign g_in = dneg_reg[s-1];
        end
        always_comb
        begin
            logic [REM_W:0] t;
            r_out = r_in;
            qb    = '0;
            for (int b = 0; b < DIV_B; b++)
            begin
                t = {r_out, n_in[DIV_W-1-b]};
                if (t >= (REM_W+1)'(trap_pkg::DIV_DEN))
                begin
                    r_out          = REM_W'(t - (REM_W+1)'(trap_pkg::DIV_DEN));
                    qb[DIV_B-1-b]  = 1'b1;
                end
                else
                begin
                    r_out = t[REM_W-1:0];
                end
            end
        end
        always_ff @(posedge clk)
        begin
            rem_reg[s]  <= r_out;
            dnum_reg[s] <= n_in << DIV_B;
            quo_reg[s]  <= {q_in[DIV_W-DIV_B-1:0], qb};
            dsgn_reg[s] <= s_in;
            dneg_reg[s] <= g_in;
        end
    end

    // Reattach the sign; the radian value always stays below 2^31.
    always_ff @(posedge clk)
    begin
        logic signed [Z_W-1:0] qz;
        qz = signed'(Z_W'(quo_reg[NDIV-1][30:0]));
        angle_reg.z   <= dsgn_reg[NDIV-1] ? -qz : qz;
        angle_reg.neg <= dneg_reg[NDIV-1];
    end

    assign angle = angle_reg;

endmodule

/* hw/rtl/trap_cordic.sv */
// Pipelined rotation-mode CORDIC giving cosine and sine, one stage a clock.
module trap_cordic (
    input  logic             clk,
    input  trap_pkg::angle_t angle,
    output trap_pkg::trig_t  trig
);

    localparam int N    = trap_pkg::NSTG;
    localparam int XY_W = trap_pkg::XY_W;
    localparam int Z_W  = trap_pkg::Z_W;

    logic signed [XY_W-1:0] x_reg [N];
    logic signed [XY_W-1:0] y_reg [N];
    logic signed [Z_W-1:0]  z_reg [N];
    logic                   n_reg [N];
    trap_pkg::trig_t        trig_reg;

    // One micro-rotation per stage.
    for (genvar i = 0; i < N; i++) begin : g_stage
        logic signed [XY_W-1:0] xi, yi;
        logic signed [Z_W-1:0]  zi;
        logic                   ni;
        logic signed [Z_W-1:0]  at;
        if (i == 0) begin : g_first
            assign xi = trap_pkg::GAIN_Q30;
            assign yi = '0;
            assign zi = angle.z;
            assign ni = angle.neg;
        end else begin : g_next
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign ni = n_reg[i-1];
        end
        assign at = signed'(Z_W'(trap_pkg::ATAN_Q30[i]));
        always_ff @(posedge clk)
        begin
            if (zi >= 0)
            begin
                x_reg[i] <= xi - (yi >>> i);
                y_reg[i] <= yi + (xi >>> i);
                z_reg[i] <= zi - at;
            end
            else
            begin
                x_reg[i] <= xi + (yi >>> i);
                y_reg[i] <= yi - (xi >>> i);
                z_reg[i] <= zi + at;
            end
            n_reg[i] <= ni;
        end
    end

    // Undo the half-turn fold.
    always_ff @(posedge clk)
    begin
        trig_reg.cos_v <= n_reg[N-1] ? 32'(-x_reg[N-1]) : 32'(x_reg[N-1]);
        trig_reg.sin_v <= n_reg[N-1] ? 32'(-y_reg[N-1]) : 32'(y_reg[N-1]);
    end

    assign trig = trig_reg;

endmodule

/* hw/rtl/trap_lane.sv */
// One vertex lane: subtract pivot, rotate, round, add pivot back and saturate.
module trap_lane (
    input  logic             clk,
    input  trap_pkg::point_t vert,
    input  trap_pkg::point_t pivot,
    input  trap_pkg::trig_t  trig,
    output trap_pkg::point_t rot
);

    logic signed [32:0]  dx_reg, dy_reg;
    logic signed [31:0]  c_reg, s_reg;
    trap_pkg::point_t    pv1_reg, pv2_reg, pv3_reg;
    logic signed [64:0]  pxc_reg, pys_reg, pxs_reg, pyc_reg;
    logic signed [65:0]  rx_reg, ry_reg;
    trap_pkg::point_t    rot_reg;

    // Round-half-up shift back to the coordinate format, pivot add and clamp.
    function automatic logic signed [31:0] finish(input logic signed [65:0] r,
                                                  input logic signed [31:0] p);
        logic signed [36:0] t;
        t = 37'(signed'(r[65:30])) + 37'(p);
        if (t > 37'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (t < -37'sd2147483648)
            return 32'sh80000000;
        else
            return t[31:0];
    endfunction

    // Differences from the pivot, exact in 33 bits.
    always_ff @(posedge clk)
    begin
        dx_reg  <= 33'(vert.x) - 33'(pivot.x);
        dy_reg  <= 33'(vert.y) - 33'(pivot.y);
        c_reg   <= trig.cos_v;
        s_reg   <= trig.sin_v;
        pv1_reg <= pivot;
    end

    // The four products.
    always_ff @(posedge clk)
    begin
        pxc_reg <= dx_reg * c_reg;
        pys_reg <= dy_reg * s_reg;
        pxs_reg <= dx_reg * s_reg;
        pyc_reg <= dy_reg * c_reg;
        pv2_reg <= pv1_reg;
    end

    // Combine the products and add the rounding constant.
    always_ff @(posedge clk)
    begin
        rx_reg  <= 66'(pxc_reg) - 66'(pys_reg) + 66'sd536870912;
        ry_reg  <= 66'(pxs_reg) + 66'(pyc_reg) + 66'sd536870912;
        pv3_reg <= pv2_reg;
    end

    // Back to coordinates.
    always_ff @(posedge clk)
    begin
        rot_reg.x <= finish(rx_reg, pv3_reg.x);
        rot_reg.y <= finish(ry_reg, pv3_reg.y);
    end

    assign rot = rot_reg;

endmodule

/* hw/rtl/triangle_rotate_about_point_top.sv */
// Top level of the triangle rotation block: angle pipeline, CORDIC, three vertex lanes.
//
// Usage: drive a request on item and raise start for one cycle; busy is always low,
// so a request is taken at every clock edge where start is high. The block accepts
// one request per cycle with no gaps, fully pipelined.
// Each request produces exactly one result. It appears on result with done high for
// exactly one cycle, once the request has passed the angle pipeline, the CORDIC and
// the vertex lanes. The pipeline depth is set by the compare-subtract stages of the
// angle wrap, the divide by 45 of the radian conversion (four bits a stage), and one
// CORDIC stage per iteration.
// The three vertex lanes run in parallel and share one cosine and sine pair.
// Reset clears the valid pipeline only; requests in flight are dropped and no
// result appears until a new request has gone through.
// The receiver cannot stall; results are never held back.
module triangle_rotate_about_point_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  trap_pkg::request_t item,
    output logic               done,
    output trap_pkg::result_t  result
);

    localparam int PAY_LAT   = trap_pkg::PAY_LAT;
    localparam int TOTAL_LAT = trap_pkg::TOTAL_LAT;

    logic [TOTAL_LAT-1:0] vld_reg;
    trap_pkg::request_t   pay_reg [PAY_LAT];
    trap_pkg::angle_t     angle;
    trap_pkg::trig_t      trig;
    trap_pkg::point_t     pivot;
    trap_pkg::point_t     rot_a, rot_b, rot_c;
    logic                 accept;

    // The pipeline never holds off a request.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Valid bits travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], accept};
        end
    end

    // Delay line that holds pivot and vertices until cosine and sine are ready.
    always_ff @(posedge clk)
    begin
        pay_reg[0] <= item;
        for (int k = 1; k < PAY_LAT; k++)
        begin
            pay_reg[k] <= pay_reg[k-1];
        end
    end

    trap_reduce u_reduce (
        .clk       (clk),
        .angle_deg (item.angle_deg),
        .angle     (angle)
    );

    trap_cordic u_cordic (
        .clk   (clk),
        .angle (angle),
        .trig  (trig)
    );

    assign pivot = '{x: pay_reg[PAY_LAT-1].pivot_x, y: pay_reg[PAY_LAT-1].pivot_y};

    trap_lane u_lane_a (
        .clk   (clk),
        .vert  ('{x: pay_reg[PAY_LAT-1].vert_a_x, y: pay_reg[PAY_LAT-1].vert_a_y}),
        .pivot (pivot),
        .trig  (trig),
        .rot   (rot_a)
    );

    trap_lane u_lane_b (
        .clk   (clk),
        .vert  ('{x: pay_reg[PAY_LAT-1].vert_b_x, y: pay_reg[PAY_LAT-1].vert_b_y}),
        .pivot (pivot),
        .trig  (trig),
        .rot   (rot_b)
    );

    trap_lane u_lane_c (
        .clk   (clk),
        .vert  ('{x: pay_reg[PAY_LAT-1].vert_c_x, y: pay_reg[PAY_LAT-1].vert_c_y}),
        .pivot (pivot),
        .trig  (trig),
        .rot   (rot_c)
    );

    // Merge the lane outputs into one result.
    assign result.rot_a_x = rot_a.x;
    assign result.rot_a_y = rot_a.y;
    assign result.rot_b_x = rot_b.x;
    assign result.rot_b_y = rot_b.y;
    assign result.rot_c_x = rot_c.x;
    assign result.rot_c_y = rot_c.y;
    assign done           = vld_reg[TOTAL_LAT-1];

endmodule

/* hw/rtl/trap_checker.sv */
// Port-level checker for the triangle rotation block, with its bind statement.
module trap_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input trap_pkg::request_t item,
    input logic               done,
    input trap_pkg::result_t  result
);

    localparam int LAT = trap_pkg::TOTAL_LAT;

    // The block never holds off a request.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // Every accepted request yields a result after the fixed latency.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing");

    // A result only appears for a request accepted exactly that long ago.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("spurious result");

    // A vertex that sits on the pivot stays on the pivot.
    a_pivot_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.vert_a_x == item.pivot_x && item.vert_a_y == item.pivot_y)
        |-> ##LAT (result.rot_a_x == $past(item.pivot_x, LAT)
                   && result.rot_a_y == $past(item.pivot_y, LAT)))
        else $error("pivot vertex moved");

endmodule

bind triangle_rotate_about_point_top trap_checker u_trap_checker (.*);

/* verif/triangle_rotate_about_point_checker.sv */
// Checker for the triangle rotation block: predicts each result and compares it.
`timescale 1ns / 1ps

module triangle_rotate_about_point_checker
    import trap_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  request_t item,
    input  logic     done,
    input  result_t  result,
    output int       fail_count,
    output int       pending
);

    result_t rotated_q[$];

    // Cosine and sine of an angle in Q16.16 degrees, both Q2.30.
    function automatic void angle_to_trig(input longint ang, output longint c,
                                          output longint s);
        longint m;
        longint x;
        longint y;
        longint z;
        longint nx;
        longint unsigned mag;
        longint unsigned rad;
        bit neg;
        m = ang % FULL_ANG;
        neg = 1'b0;
        x = GAIN_Q30;
        y = 0;
        if (m < 0)
            m += FULL_ANG;
        // Fold into [-90, 90] degrees; the middle half turn negates the pair.
        if (m > QUARTER_ANG && m <= 3 * QUARTER_ANG)
        begin
            m -= HALF_ANG;
            neg = 1'b1;
        end
        else if (m > 3 * QUARTER_ANG)
        begin
            m -= FULL_ANG;
        end
        mag = (m < 0) ? -m : m;
        rad = (mag * longint'(PI_Q30) + (HALF_ANG >> 1)) / HALF_ANG;
        z = (m < 0) ? -longint'(rad) : longint'(rad);
        for (int i = 0; i < NSTG; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= longint'(ATAN_Q30[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += longint'(ATAN_Q30[i]);
            end
            x = nx;
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    function automatic logic signed [31:0] clamp_coord(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // Rotate one vertex about the pivot; products wrap at 64 bits, unlike the 66-bit hardware sums.
    function automatic void turn_vertex(input longint vx, input longint vy,
                                        input longint px, input longint py,
                                        input longint c, input longint s,
                                        output logic signed [31:0] ox,
                                        output logic signed [31:0] oy);
        longint dx;
        longint dy;
        longint rx;
        longint ry;
        dx = vx - px;
        dy = vy - py;
        rx = dx * c - dy * s;
        ry = dx * s + dy * c;
        rx = (rx + (64'sd1 << 29)) >>> 30;
        ry = (ry + (64'sd1 << 29)) >>> 30;
        ox = clamp_coord(rx + px);
        oy = clamp_coord(ry + py);
    endfunction

    function automatic result_t rotate_triangle(input request_t r);
        result_t o;
        longint c;
        longint s;
        angle_to_trig(longint'(r.angle_deg), c, s);
        turn_vertex(r.vert_a_x, r.vert_a_y, r.pivot_x, r.pivot_y, c, s,
                    o.rot_a_x, o.rot_a_y);
        turn_vertex(r.vert_b_x, r.vert_b_y, r.pivot_x, r.pivot_y, c, s,
                    o.rot_b_x, o.rot_b_y);
        turn_vertex(r.vert_c_x, r.vert_c_y, r.pivot_x, r.pivot_y, c, s,
                    o.rot_c_x, o.rot_c_y);
        return o;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
            fail_count++;
        end
    endtask

    assign pending = rotated_q.size();

    // Record each accepted request and compare each strobed result.
    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
        begin
            rotated_q.delete();
        end
        else
        begin
            if (start && !busy)
                rotated_q.push_back(rotate_triangle(item));
            if (done)
            begin
                if (rotated_q.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    e = rotated_q.pop_front();
                    check_field("rot_a_x", e.rot_a_x, result.rot_a_x);
                    check_field("rot_a_y", e.rot_a_y, result.rot_a_y);
                    check_field("rot_b_x", e.rot_b_x, result.rot_b_x);
                    check_field("rot_b_y", e.rot_b_y, result.rot_b_y);
                    check_field("rot_c_x", e.rot_c_x, result.rot_c_x);
                    check_field("rot_c_y", e.rot_c_y, result.rot_c_y);
                end
            end
        end
    end

    initial fail_count = 0;

endmodule

/* verif/triangle_rotate_about_point_top_tb.sv */
// Testbench top for the triangle rotation block: stimulus, checker hookup and verdict.
`timescale 1ns / 1ps

module triangle_rotate_about_point_top_tb;
    import trap_pkg::*;

    localparam int RANDOM_ITEMS = 1100;
    localparam int CYCLE_LIMIT  = 200000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    request_t item;
    logic     done;
    result_t  result;
    int       fail_count;
    int       pending;
    int       cycles;

    triangle_rotate_about_point_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    triangle_rotate_about_point_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .done       (done),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit.
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Coordinate mix: full range, small values near zero, or the extremes.
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0, 1:    return $urandom();
            2:       return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 255)
                                                 : 32'h80000000 + $urandom_range(0, 255);
            default: return 32'($signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh00FFFFFF);
        endcase
    endfunction

    // Angle mix: any value, near a quadrant boundary, or within a few turns.
    function automatic logic [31:0] pick_angle();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return 32'(($signed($urandom_range(0, 16)) - 8) * QUARTER_ANG
                            + $signed($urandom_range(0, 4)) - 2);
            default: return 32'($signed($urandom_range(0, 32'h0B400000)) - 32'sh05A00000);
        endcase
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic send_request(input request_t r);
        item  <= r;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic send_triangle(input logic [31:0] ang, input logic [31:0] px,
                                 input logic [31:0] py, input logic [31:0] v);
        request_t r;
        r.angle_deg = ang;
        r.pivot_x   = px;
        r.pivot_y   = py;
        r.vert_a_x  = v;
        r.vert_a_y  = ~v;
        r.vert_b_x  = 32'h00010000;
        r.vert_b_y  = 32'hFFFF0000;
        r.vert_c_x  = 32'h7FFFFFFF;
        r.vert_c_y  = 32'h80000000;
        send_request(r);
    endtask

    initial
    begin
        request_t r;
        int left;
        int gap;
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: quadrant boundaries, large angles, distant pivots, saturation.
        send_triangle(32'h00000000, 32'h0, 32'h0, 32'h00020000);
        send_triangle(32'(QUARTER_ANG), 32'h0, 32'h0, 32'h00020000);
        send_triangle(32'(QUARTER_ANG + 1), 32'h0, 32'h0, 32'h00020000);
        send_triangle(32'(HALF_ANG), 32'h00010000, 32'h0, 32'h00020000);
        send_triangle(32'(3 * QUARTER_ANG), 32'h0, 32'h00010000, 32'h00020000);
        send_triangle(32'(3 * QUARTER_ANG + 1), 32'h0, 32'h0, 32'h00030000);
        send_triangle(32'(-QUARTER_ANG), 32'h0, 32'h0, 32'h00020000);
        send_triangle(32'(FULL_ANG), 32'h0, 32'h0, 32'h00020000);
        send_triangle(32'(-FULL_ANG), 32'h0, 32'h0, 32'h00020000);
        send_triangle(32'h002D0000, 32'h0, 32'h0, 32'h7FFFFFFF);
        send_triangle(32'hFFD30000, 32'h0, 32'h0, 32'h80000000);
        send_triangle(32'h7FFFFFFF, 32'h0, 32'h0, 32'h12345678);
        send_triangle(32'h80000000, 32'h0, 32'h0, 32'h12345678);
        send_triangle(32'(HALF_ANG), 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
        send_triangle(32'(HALF_ANG), 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        send_triangle(32'(QUARTER_ANG), 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_triangle(32'h001E8000, 32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF);
        send_triangle(32'(-HALF_ANG), 32'h7FFFFFFF, 32'h80000000, 32'h0);
        send_triangle(32'h00000001, 32'h0, 32'h0, 32'h7FFFFFFF);

        // Random requests in bursts with random gaps.
        left = RANDOM_ITEMS;
        while (left > 0)
        begin
            for (int n = $urandom_range(1, 40); n > 0 && left > 0; n--)
            begin
                r.angle_deg = pick_angle();
                r.pivot_x   = pick_coord();
                r.pivot_y   = pick_coord();
                r.vert_a_x  = pick_coord();
                r.vert_a_y  = pick_coord();
                r.vert_b_x  = pick_coord();
                r.vert_b_y  = pick_coord();
                r.vert_c_x  = pick_coord();
                r.vert_c_y  = pick_coord();
                send_request(r);
                left--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        start <= 1'b0;

        // Drain the pipeline, then wait longer than the pipeline latency for stray results.
        while (pending != 0)
            @(posedge clk);
        repeat (TOTAL_LAT + 10) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
